// ===== sv/ssdt_pkg.sv =====
// ----------------------------------------------------------------------------
// ssdt_pkg
// Shared types and constants for the sparse-set dirty table.
// ----------------------------------------------------------------------------
package ssdt_pkg;

  localparam int unsigned DefMaxIds   = 1024;
  localparam int unsigned DefMaxSlots = 1024;
  localparam int unsigned IdW         = 10;
  localparam int unsigned OpW         = 3;
  localparam int unsigned SlotOutW    = 10;
  localparam int unsigned CountOutW   = 11;

  localparam logic [OpW-1:0] OP_ADD    = 3'd0;
  localparam logic [OpW-1:0] OP_REMOVE = 3'd1;
  localparam logic [OpW-1:0] OP_HAS    = 3'd2;
  localparam logic [OpW-1:0] OP_MARK   = 3'd3;
  localparam logic [OpW-1:0] OP_FETCH  = 3'd4;
  localparam logic [OpW-1:0] OP_CLEAR  = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic [IdW-1:0] id;
  } cmd_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 present;
    logic [SlotOutW-1:0]  slot;
    logic                 rebuild;
    logic [CountOutW-1:0] live;
  } rsp_t;

endpackage

// ===== sv/ssdt_front.sv =====
// ----------------------------------------------------------------------------
// ssdt_front
// Accepts commands and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module ssdt_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ssdt_pkg::cmd_t  in_cmd,
  output logic            q_valid,
  input  logic            q_ready,
  output ssdt_pkg::cmd_t  q_cmd
);

  ssdt_pkg::cmd_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_cmd;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/ssdt_engine.sv =====
// ----------------------------------------------------------------------------
// ssdt_engine
// Executes one command at a time against the sparse, dense and dirty stores.
// ----------------------------------------------------------------------------
module ssdt_engine #(
  parameter int unsigned MAX_IDS   = ssdt_pkg::DefMaxIds,
  parameter int unsigned MAX_SLOTS = ssdt_pkg::DefMaxSlots
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  ssdt_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output ssdt_pkg::rsp_t rsp
);

  localparam int unsigned AW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int unsigned SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned XW = ssdt_pkg::IdW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_MOVE = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [SW-1:0] sparse_mem [MAX_IDS];
  logic [AW-1:0] owner_mem  [MAX_SLOTS];
  logic          dirty_mem  [MAX_SLOTS];

  logic [2:0]     state_r;
  ssdt_pkg::cmd_t cmd_r;
  logic [CW-1:0]  count_r;
  logic [SW-1:0]  sp_rd_r;
  logic [AW-1:0]  own_rd_r;
  logic           dirty_rd_r;
  logic [SW-1:0]  slot_r;
  ssdt_pkg::rsp_t rsp_r;
  ssdt_pkg::rsp_t rsp_nxt;

  // Single read address per store; the dense-side address is selected by the sequencer state.
  logic [SW-1:0] dense_raddr;
  logic          id_in_range;
  logic [SW-1:0] last_slot;
  logic          lookup_hit;

  assign id_in_range = ({1'b0, cmd_r.id} < XW'(MAX_IDS));
  assign last_slot   = SW'(count_r - CW'(1));
  assign dense_raddr = (state_r == S_EXEC) ? last_slot : sp_rd_r;
  // The owner of the sparse entry's slot is registered at the end of S_RD2,
  // so the cross-check is valid during S_EXEC.
  assign lookup_hit  = id_in_range && (CW'(sp_rd_r) < count_r)
                       && (own_rd_r == AW'(cmd_r.id));

  assign cmd_ready = (state_r == S_IDLE);
  assign rsp_valid = (state_r == S_OUT);
  assign rsp       = rsp_r;

  always_comb begin
    rsp_nxt         = '0;
    rsp_nxt.status  = ssdt_pkg::ST_OK;
    rsp_nxt.present = lookup_hit;
    rsp_nxt.slot    = lookup_hit ? ssdt_pkg::SlotOutW'(slot_r) : '0;
    rsp_nxt.live    = ssdt_pkg::CountOutW'(count_r);
    unique case (cmd_r.op)
      ssdt_pkg::OP_ADD: begin
        if (!lookup_hit) begin
          if (!id_in_range) begin
            rsp_nxt.status = ssdt_pkg::ST_RANGE;
          end else if (count_r >= CW'(MAX_SLOTS)) begin
            rsp_nxt.status = ssdt_pkg::ST_FULL;
          end else begin
            rsp_nxt.slot = ssdt_pkg::SlotOutW'(count_r);
            rsp_nxt.live = ssdt_pkg::CountOutW'(count_r + CW'(1));
          end
        end
      end
      ssdt_pkg::OP_REMOVE, ssdt_pkg::OP_HAS, ssdt_pkg::OP_MARK: begin
        if (!lookup_hit) rsp_nxt.status = ssdt_pkg::ST_ABSENT;
      end
      ssdt_pkg::OP_FETCH: begin
        if (lookup_hit) rsp_nxt.rebuild = dirty_rd_r;
        else rsp_nxt.status = ssdt_pkg::ST_ABSENT;
      end
      ssdt_pkg::OP_CLEAR: begin
        rsp_nxt.present = 1'b0;
        rsp_nxt.slot    = '0;
        rsp_nxt.live    = '0;
      end
      default: begin
        rsp_nxt.present = 1'b0;
        rsp_nxt.slot    = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RD1) begin
      sp_rd_r <= sparse_mem[AW'(cmd_r.id)];
    end
    own_rd_r   <= owner_mem[dense_raddr];
    dirty_rd_r <= dirty_mem[dense_raddr];

    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r   <= cmd;
            state_r <= S_RD1;
          end
        end
        S_RD1: state_r <= S_RD2;
        S_RD2: begin
          slot_r  <= sp_rd_r;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          rsp_r <= rsp_nxt;
          // Next cycle the last slot's owner and mark are in the read regs.
          state_r <= (cmd_r.op == ssdt_pkg::OP_REMOVE && lookup_hit) ? S_MOVE : S_OUT;
          unique case (cmd_r.op)
            ssdt_pkg::OP_ADD: begin
              if (lookup_hit) begin
                dirty_mem[slot_r] <= 1'b1;
              end else if (id_in_range && count_r < CW'(MAX_SLOTS)) begin
                owner_mem[SW'(count_r)]   <= AW'(cmd_r.id);
                dirty_mem[SW'(count_r)]   <= 1'b1;
                sparse_mem[AW'(cmd_r.id)] <= SW'(count_r);
                count_r <= count_r + CW'(1);
              end
            end
            ssdt_pkg::OP_MARK: begin
              if (lookup_hit) dirty_mem[slot_r] <= 1'b1;
            end
            ssdt_pkg::OP_FETCH: begin
              if (lookup_hit) dirty_mem[slot_r] <= 1'b0;
            end
            ssdt_pkg::OP_CLEAR: begin
              count_r <= '0;
            end
            default: begin
            end
          endcase
        end
        S_MOVE: begin
          if (slot_r != last_slot) begin
            owner_mem[slot_r]    <= own_rd_r;
            dirty_mem[slot_r]    <= dirty_rd_r;
            sparse_mem[own_rd_r] <= slot_r;
          end
          count_r    <= count_r - CW'(1);
          rsp_r.live <= ssdt_pkg::CountOutW'(count_r - CW'(1));
          state_r    <= S_OUT;
        end
        S_OUT: begin
          if (rsp_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/sparse_set_dirty_table.sv =====
// ----------------------------------------------------------------------------
// sparse_set_dirty_table
// Sparse-to-dense entity map with swap-remove and a dirty mark per slot.
// ----------------------------------------------------------------------------
// Usage: commands enter on the in_ stream (operation, entity_id); one result
// per command leaves on the out_ stream (status, present, slot, rebuild flag,
// live count). A two-entry command queue decouples the input from the engine,
// so the source may keep sending while a result waits.
// The engine handles one command at a time: it takes one from the queue in
// S_IDLE, reads the sparse entry in S_RD1 and its dense owner in S_RD2,
// executes in S_EXEC and holds the result in S_OUT until out_tready takes
// it; a remove that hits passes through S_MOVE first to move the last slot
// into the hole. The engine takes no new command until its last result has
// been accepted, and each synchronous store has a single read port.
// Reset empties the table at once (count to zero); the stores hold no reset
// value and are never read unchecked. While out_tready is low the result holds
// and the engine waits; the queue then fills and in_tready drops.
// ----------------------------------------------------------------------------
module sparse_set_dirty_table #(
  parameter int unsigned MAX_IDS   = ssdt_pkg::DefMaxIds,
  parameter int unsigned MAX_SLOTS = ssdt_pkg::DefMaxSlots
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [2:0] operation, [12:3] entity_id
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [1:0] status, [2] present, [12:3] slot_index,
                                  // [13] needs_rebuild, [24:14] live_entries
);

  ssdt_pkg::cmd_t in_cmd, q_cmd;
  ssdt_pkg::rsp_t rsp;
  logic           q_valid, q_ready;

  assign in_cmd = ssdt_pkg::cmd_t'({in_tdata[2:0], in_tdata[12:3]});

  ssdt_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_cmd(in_cmd),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  ssdt_engine #(.MAX_IDS(MAX_IDS), .MAX_SLOTS(MAX_SLOTS)) u_engine (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .rsp_valid(out_tvalid), .rsp_ready(out_tready), .rsp(rsp)
  );

  assign out_tdata = {7'd0, rsp.live, rsp.rebuild, rsp.slot, rsp.present, rsp.status};

endmodule

// ===== sim/sparse_set_dirty_table_tb.sv =====
// ----------------------------------------------------------------------------
// sparse_set_dirty_table_tb
// Self-checking testbench: directed and random command streams are driven on
// the input stream, a behavioral table predicts every result, and the monitor
// compares each result transaction field by field.
// ----------------------------------------------------------------------------
module sparse_set_dirty_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumIds = 1024;

  typedef struct packed {
    logic [2:0] op;
    logic [9:0] id;
  } table_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        present;
    logic [9:0]  slot;
    logic        rebuild;
    logic [10:0] live;
  } table_rsp_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [2:0] operation, [12:3] entity_id
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [1:0] status, [2] present, [12:3] slot_index,
                           // [13] needs_rebuild, [24:14] live_entries

  sparse_set_dirty_table i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Predictor state.
  logic [9:0]  map_slot [NumIds];
  logic [9:0]  slot_owner [NumIds];
  logic        slot_dirty [NumIds];
  logic [10:0] live_count;

  table_cmd_t pending_cmds[$];
  table_rsp_t expected_rsps[$];
  int         error_count;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         hold_cycles;
  logic       in_tready_seen;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic table_rsp_t predict_table(table_cmd_t c);
    table_rsp_t r;
    logic [9:0] s;
    logic       hit;
    logic [9:0] last;
    s   = map_slot[c.id];
    hit = ({1'b0, s} < live_count) && (slot_owner[s] == c.id);
    r = '0;
    if (hit) begin
      r.present = 1'b1;
      r.slot    = s;
    end
    unique case (c.op)
      ssdt_pkg::OP_ADD: begin
        if (hit) begin
          slot_dirty[s] = 1'b1;
        end else if (live_count >= 11'd1024) begin
          r.status = ssdt_pkg::ST_FULL;
        end else begin
          slot_owner[live_count[9:0]] = c.id;
          slot_dirty[live_count[9:0]] = 1'b1;
          map_slot[c.id] = live_count[9:0];
          r.slot = live_count[9:0];
          live_count = live_count + 11'd1;
        end
      end
      ssdt_pkg::OP_REMOVE: begin
        if (hit) begin
          last = live_count[9:0] - 10'd1;
          if (s != last) begin
            slot_owner[s] = slot_owner[last];
            slot_dirty[s] = slot_dirty[last];
            map_slot[slot_owner[last]] = s;
          end
          live_count = live_count - 11'd1;
        end else begin
          r.status = ssdt_pkg::ST_ABSENT;
        end
      end
      ssdt_pkg::OP_HAS: begin
        if (!hit) r.status = ssdt_pkg::ST_ABSENT;
      end
      ssdt_pkg::OP_MARK: begin
        if (hit) slot_dirty[s] = 1'b1;
        else r.status = ssdt_pkg::ST_ABSENT;
      end
      ssdt_pkg::OP_FETCH: begin
        if (hit) begin
          r.rebuild = slot_dirty[s];
          slot_dirty[s] = 1'b0;
        end else begin
          r.status = ssdt_pkg::ST_ABSENT;
        end
      end
      ssdt_pkg::OP_CLEAR: begin
        live_count = '0;
        r.present = 1'b0;
        r.slot = '0;
      end
      default: begin
        r.present = 1'b0;
        r.slot = '0;
      end
    endcase
    r.live = live_count;
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  // Driver: the transaction moves at the rising edge, new values at the falling one.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready_seen) begin
        if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_tdata  <= {3'b000, pending_cmds[0].id, pending_cmds[0].op};
          in_tvalid <= 1'b1;
          pending_cmds.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= (hold_cycles > 0) ? 1'b0 : ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    in_tready_seen <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      expected_rsps = {expected_rsps,
                       predict_table(table_cmd_t'({in_tdata[2:0], in_tdata[12:3]}))};
  end

  // Long receiver hold-off, counted down in cycles.
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // Monitor.
  always @(posedge clk) begin
    table_rsp_t got;
    table_rsp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[1:0], out_tdata[2], out_tdata[12:3], out_tdata[13], out_tdata[24:14]};
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_rsps.pop_front();
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.present != want.present) report_mismatch("present", got.present, want.present);
        if (got.slot != want.slot) report_mismatch("slot_index", got.slot, want.slot);
        if (got.rebuild != want.rebuild)
          report_mismatch("needs_rebuild", got.rebuild, want.rebuild);
        if (got.live != want.live) report_mismatch("live_entries", got.live, want.live);
      end
    end
  end

  function automatic table_cmd_t make_cmd(logic [2:0] op, logic [9:0] id);
    table_cmd_t c;
    c.op = op;
    c.id = id;
    return c;
  endfunction

  task automatic queue_cmd(logic [2:0] op, logic [9:0] id);
    pending_cmds = {pending_cmds, make_cmd(op, id)};
  endtask

  // Random ids come from the given pool most of the time, so a small pool gets entries reused.
  function automatic logic [9:0] pick_id(int pool);
    if ($urandom_range(9, 0) == 0) return 10'($urandom_range(1023, 0));
    return 10'($urandom_range(pool - 1, 0));
  endfunction

  task automatic queue_random(int count, int pool, int add_weight);
    int k;
    int w;
    logic [2:0] op;
    for (k = 0; k < count; k++) begin
      w = $urandom_range(99, 0);
      if (w < add_weight) op = ssdt_pkg::OP_ADD;
      else if (w < add_weight + 15) op = ssdt_pkg::OP_REMOVE;
      else if (w < add_weight + 25) op = ssdt_pkg::OP_HAS;
      else if (w < add_weight + 35) op = ssdt_pkg::OP_MARK;
      else if (w < add_weight + 50) op = ssdt_pkg::OP_FETCH;
      else if (w < 99) op = ssdt_pkg::OP_HAS;
      else op = ($urandom_range(1, 0) != 0) ? ssdt_pkg::OP_CLEAR : 3'($urandom_range(7, 6));
      queue_cmd(op, pick_id(pool));
    end
  endtask

  task automatic queue_fill(int first, int stop);
    int k;
    for (k = first; k < stop; k++) queue_cmd(ssdt_pkg::OP_ADD, 10'(k));
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_tvalid || expected_rsps.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int k;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    live_count = '0;
    for (k = 0; k < NumIds; k++) begin
      map_slot[k] = '0;
      slot_owner[k] = '0;
      slot_dirty[k] = 1'b0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: every operation, extremes of the id, swap-remove of the first slot.
    queue_cmd(ssdt_pkg::OP_HAS, 10'd0);
    queue_cmd(ssdt_pkg::OP_ADD, 10'd0);
    queue_cmd(ssdt_pkg::OP_ADD, 10'd1023);
    queue_cmd(ssdt_pkg::OP_ADD, 10'd512);
    queue_cmd(ssdt_pkg::OP_ADD, 10'd0);
    queue_cmd(ssdt_pkg::OP_FETCH, 10'd0);
    queue_cmd(ssdt_pkg::OP_FETCH, 10'd0);
    queue_cmd(ssdt_pkg::OP_MARK, 10'd0);
    queue_cmd(ssdt_pkg::OP_FETCH, 10'd1023);
    queue_cmd(ssdt_pkg::OP_REMOVE, 10'd0);
    queue_cmd(ssdt_pkg::OP_FETCH, 10'd512);
    queue_cmd(ssdt_pkg::OP_HAS, 10'd0);
    queue_cmd(ssdt_pkg::OP_REMOVE, 10'd0);
    queue_cmd(ssdt_pkg::OP_MARK, 10'd341);
    queue_cmd(ssdt_pkg::OP_FETCH, 10'd682);
    queue_cmd(ssdt_pkg::OP_REMOVE, 10'd512);
    queue_cmd(3'd6, 10'd1023);
    queue_cmd(3'd7, 10'd0);
    queue_cmd(ssdt_pkg::OP_CLEAR, 10'd1023);
    queue_cmd(ssdt_pkg::OP_HAS, 10'd1023);
    queue_cmd(ssdt_pkg::OP_ADD, 10'd1023);
    wait_drained();

    // No idling.
    queue_random(40, 48, 40);
    wait_drained();

    // Receiver holds off long while the sender keeps offering, so input stalls.
    hold_cycles = 60;
    queue_random(30, 48, 40);
    wait_drained();

    // Fill the table completely across the idling phases.
    queue_cmd(ssdt_pkg::OP_CLEAR, 10'd0);
    queue_fill(0, 256);
    wait_drained();

    send_idle_pct = 62;
    queue_fill(256, 512);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 62;
    queue_fill(512, 768);
    wait_drained();

    send_idle_pct = 27;
    recv_stall_pct = 27;
    queue_fill(768, 1024);
    wait_drained();

    // Work on the full table, then swap-remove and re-add.
    queue_random(20, 1024, 30);
    queue_cmd(ssdt_pkg::OP_REMOVE, 10'd5);
    queue_cmd(ssdt_pkg::OP_ADD, 10'd5);
    queue_cmd(ssdt_pkg::OP_ADD, 10'd5);
    queue_random(30, 1024, 20);
    wait_drained();

    repeat (40) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
